@@ hw/rtl/vts_pkg.sv @@
// Shared types and constants for the vertex transform and screen mapping block.
`timescale 1ns / 1ps

package vts_pkg;

    localparam int COEF_W      = 32;
    localparam int IDX_W       = 4;
    localparam int MAT_N       = 16;
    localparam int VEC_N       = 4;
    localparam int SCR_W       = 16;
    localparam int IN_TDATA_W  = 168;
    localparam int OUT_TDATA_W = 160;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int HALF_W      = 11;
    localparam int OFS_W       = 10;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic MODE_COEF   = 1'b0;
    localparam logic MODE_VERTEX = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET    = 4'd3;

    localparam logic [HALF_W-1:0] HALF_WIDTH_RST  = 11'd160;
    localparam logic [HALF_W-1:0] HALF_HEIGHT_RST = 11'd120;
    localparam logic [OFS_W-1:0]  X_OFFSET_RST    = 10'd0;
    localparam logic [OFS_W-1:0]  Y_OFFSET_RST    = 10'd10;

    typedef struct packed {
        logic                          is_vertex;
        logic [IDX_W-1:0]              idx;
        logic [COEF_W-1:0]             coef;
        logic [VEC_N-1:0][COEF_W-1:0]  vtx;
    } t_cmd;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

@@ hw/rtl/vts_front.sv @@
// Input stage that accepts stream requests and decodes them into queue commands.
`timescale 1ns / 1ps

module vts_front import vts_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_TDATA_W-1:0] i_s_tdata,  // coef_index, coef_value, vx, vy, vz, vw, zero pad
    input  logic                  i_s_tuser,  // mode
    output logic                  o_cmd_valid,
    input  logic                  i_cmd_ready,
    output t_cmd                  o_cmd
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    assign o_s_tready = !r_valid || i_cmd_ready;

    always_comb begin
        n_cmd.is_vertex = (i_s_tuser == MODE_VERTEX);
        n_cmd.idx       = i_s_tdata[3:0];
        n_cmd.coef      = i_s_tdata[35:4];
        n_cmd.vtx[0]    = i_s_tdata[67:36];
        n_cmd.vtx[1]    = i_s_tdata[99:68];
        n_cmd.vtx[2]    = i_s_tdata[131:100];
        n_cmd.vtx[3]    = i_s_tdata[163:132];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

@@ hw/rtl/vts_queue.sv @@
// Short command queue between the front and back parts.
`timescale 1ns / 1ps

module vts_queue import vts_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  logic i_ready,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = i_ready && o_valid;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> r_count == '0)
        else $error("queue not empty after reset");
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not follow a push");
`endif

endmodule

@@ hw/rtl/vts_back.sv @@
// Matrix store, dot-product pipeline, screen mapping and output register.
`timescale 1ns / 1ps

module vts_back import vts_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    output logic                   o_cmd_ready,
    input  t_cmd                   i_cmd,
    input  t_cfg_wr                i_cfg,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int PROD_W = 2 * COEF_W;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam int SW     = 38;
    localparam int TW     = (SW - FRAC_BITS > SCR_W) ? SW - FRAC_BITS : SCR_W + 1;
    localparam int FW     = TW + 1;

    logic [HALF_W-1:0] r_half_w;
    logic [HALF_W-1:0] r_half_h;
    logic [OFS_W-1:0]  r_ofs_x;
    logic [OFS_W-1:0]  r_ofs_y;

    logic [MAT_N-1:0][COEF_W-1:0] r_mat;
    logic [MAT_N-1:0][COEF_W-1:0] w_ident;

    logic r_a_valid, r_b_valid, r_c_valid, r_d_valid, r_e_valid, r_f_valid;
    logic a_ready, b_ready, c_ready, d_ready, e_ready, f_ready;
    logic a_to_b;
    t_cmd r_a_cmd;

    logic signed [PROD_W-1:0] r_b_prod [VEC_N][VEC_N];
    logic signed [PAIR_W-1:0] r_c_pair [VEC_N][2];
    logic signed [SUM_W-1:0]  w_d_sum  [VEC_N];
    logic signed [SUM_W-1:0]  w_d_sh   [VEC_N];
    logic [COEF_W-1:0]        w_d_row  [VEC_N];
    logic [COEF_W-1:0]        r_d_row  [VEC_N];
    logic [COEF_W-1:0]        r_e_row  [VEC_N];
    logic [COEF_W-1:0]        r_f_row  [VEC_N];

    logic signed [SW-1:0] w_e_sx, w_e_sy, w_e_flx, w_e_fly;
    logic signed [TW-1:0] w_e_tx, w_e_ty, r_e_tx, r_e_ty;
    logic signed [FW-1:0] w_f_x, w_f_y;
    logic [SCR_W-1:0]     w_f_sx, w_f_sy, r_f_sx, r_f_sy;

    genvar gi;
    generate
        for (gi = 0; gi < MAT_N; gi++) begin : g_ident
            assign w_ident[gi] = ((gi % 5) == 0) ? (COEF_W'(1) << FRAC_BITS) : '0;
        end
    endgenerate

    assign f_ready     = !r_f_valid || i_m_tready;
    assign e_ready     = !r_e_valid || f_ready;
    assign d_ready     = !r_d_valid || e_ready;
    assign c_ready     = !r_c_valid || d_ready;
    assign b_ready     = !r_b_valid || c_ready;
    assign a_ready     = !r_a_valid || !r_a_cmd.is_vertex || b_ready;
    assign a_to_b      = r_a_valid && r_a_cmd.is_vertex;
    assign o_cmd_ready = a_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_w <= HALF_WIDTH_RST;
            r_half_h <= HALF_HEIGHT_RST;
            r_ofs_x  <= X_OFFSET_RST;
            r_ofs_y  <= Y_OFFSET_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_HALF_WIDTH:  r_half_w <= i_cfg.data[HALF_W-1:0];
                REG_HALF_HEIGHT: r_half_h <= i_cfg.data[HALF_W-1:0];
                REG_X_OFFSET:    r_ofs_x  <= i_cfg.data[OFS_W-1:0];
                REG_Y_OFFSET:    r_ofs_y  <= i_cfg.data[OFS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat <= w_ident;
        end else if (r_a_valid && !r_a_cmd.is_vertex) begin
            r_mat[r_a_cmd.idx] <= r_a_cmd.coef;
        end
    end

    always_comb begin
        for (int r = 0; r < VEC_N; r++) begin
            w_d_sum[r] = SUM_W'(r_c_pair[r][0]) + SUM_W'(r_c_pair[r][1]);
            w_d_sh[r]  = w_d_sum[r] >>> FRAC_BITS;
            if ((&w_d_sh[r][SUM_W-1:COEF_W-1]) || !(|w_d_sh[r][SUM_W-1:COEF_W-1])) begin
                w_d_row[r] = w_d_sh[r][COEF_W-1:0];
            end else if (w_d_sh[r][SUM_W-1]) begin
                w_d_row[r] = {1'b1, {(COEF_W-1){1'b0}}};
            end else begin
                w_d_row[r] = {1'b0, {(COEF_W-1){1'b1}}};
            end
        end
    end

    always_comb begin
        w_e_sx  = SW'($signed(r_d_row[0])) + (SW'(r_half_w) << FRAC_BITS);
        w_e_sy  = (SW'(r_half_h) << FRAC_BITS) - SW'($signed(r_d_row[1]));
        w_e_flx = w_e_sx >>> FRAC_BITS;
        w_e_fly = w_e_sy >>> FRAC_BITS;
        w_e_tx  = TW'(w_e_flx) + TW'(w_e_sx[SW-1] && (|w_e_sx[FRAC_BITS-1:0]));
        w_e_ty  = TW'(w_e_fly) + TW'(w_e_sy[SW-1] && (|w_e_sy[FRAC_BITS-1:0]));
    end

    always_comb begin
        w_f_x = FW'(r_e_tx) + FW'(r_ofs_x);
        w_f_y = FW'(r_e_ty) + FW'(r_ofs_y);
        if ((&w_f_x[FW-1:SCR_W-1]) || !(|w_f_x[FW-1:SCR_W-1])) begin
            w_f_sx = w_f_x[SCR_W-1:0];
        end else begin
            w_f_sx = w_f_x[FW-1] ? {1'b1, {(SCR_W-1){1'b0}}} : {1'b0, {(SCR_W-1){1'b1}}};
        end
        if ((&w_f_y[FW-1:SCR_W-1]) || !(|w_f_y[FW-1:SCR_W-1])) begin
            w_f_sy = w_f_y[SCR_W-1:0];
        end else begin
            w_f_sy = w_f_y[FW-1] ? {1'b1, {(SCR_W-1){1'b0}}} : {1'b0, {(SCR_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_cmd_valid;
            end
            if (b_ready) begin
                r_b_valid <= a_to_b;
            end
            if (c_ready) begin
                r_c_valid <= r_b_valid;
            end
            if (d_ready) begin
                r_d_valid <= r_c_valid;
            end
            if (e_ready) begin
                r_e_valid <= r_d_valid;
            end
            if (f_ready) begin
                r_f_valid <= r_e_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_cmd_valid) begin
            r_a_cmd <= i_cmd;
        end
        if (b_ready && a_to_b) begin
            for (int r = 0; r < VEC_N; r++) begin
                for (int c = 0; c < VEC_N; c++) begin
                    r_b_prod[r][c] <= $signed(r_mat[r*VEC_N+c]) * $signed(r_a_cmd.vtx[c]);
                end
            end
        end
        if (c_ready && r_b_valid) begin
            for (int r = 0; r < VEC_N; r++) begin
                r_c_pair[r][0] <= PAIR_W'(r_b_prod[r][0]) + PAIR_W'(r_b_prod[r][1]);
                r_c_pair[r][1] <= PAIR_W'(r_b_prod[r][2]) + PAIR_W'(r_b_prod[r][3]);
            end
        end
        if (d_ready && r_c_valid) begin
            r_d_row <= w_d_row;
        end
        if (e_ready && r_d_valid) begin
            r_e_row <= r_d_row;
            r_e_tx  <= w_e_tx;
            r_e_ty  <= w_e_ty;
        end
        if (f_ready && r_e_valid) begin
            r_f_row <= r_e_row;
            r_f_sx  <= w_f_sx;
            r_f_sy  <= w_f_sy;
        end
    end

    assign o_m_tvalid = r_f_valid;
    assign o_m_tdata  = {r_f_sy, r_f_sx, r_f_row[3], r_f_row[2], r_f_row[1], r_f_row[0]};

`ifndef SYNTHESIS
    a_b_from_vertex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_b_valid) |-> $past(r_a_valid && r_a_cmd.is_vertex))
        else $error("coefficient request entered the multiply stage");
    a_mat_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_mat) |-> $past(r_a_valid && !r_a_cmd.is_vertex))
        else $error("matrix changed without a coefficient request");
    a_mat_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> r_mat == w_ident)
        else $error("matrix is not identity after reset");
`endif

endmodule

@@ hw/rtl/vertex_transform_screen_map.sv @@
// Top level of the vertex transform and screen mapping block.
//
//  Channel  Direction  Handshake                Payload
//  s        in         i_s_tvalid/o_s_tready    i_s_tdata, i_s_tuser (mode)
//  m        out        o_m_tvalid/i_m_tready    o_m_tdata
//  cfg      in         i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
// One request is accepted per cycle unless a stall on the output holds the input; a vertex
// request gives its result after the front register, the queue and the six back stages.
// A coefficient request is written into the matrix from the first back stage and gives no result.
// Synchronous reset restores the identity matrix and the register defaults at once.
// A stall on the output backs up stage by stage into the queue and then the front.
`timescale 1ns / 1ps

module vertex_transform_screen_map import vts_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // coef_index, coef_value, vx, vy, vz, vw, zero pad
    input  logic                   i_s_tuser,   // mode
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // out_x, out_y, out_z, out_w, screen_x, screen_y
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic    f_valid, f_ready;
    t_cmd    f_cmd;
    logic    q_valid, q_ready;
    t_cmd    q_cmd;
    t_cfg_wr cfg_wr;

    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.valid = i_cfg_valid;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    vts_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready),
        .o_cmd       (f_cmd)
    );

    vts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_cmd   (f_cmd),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_cmd   (q_cmd)
    );

    vts_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .i_cfg       (cfg_wr),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

@@ test/tb_vertex_transform_screen_map.sv @@
// Self-checking testbench for the vertex transform and screen mapping block.
`timescale 1ns / 1ps

module tb_vertex_transform_screen_map;
    import vts_pkg::*;

    localparam int FRAC_BITS     = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int LATENCY_PAUSE = 16;
    localparam int CFG_REGS      = 4;
    localparam int OUT_FIELDS    = 6;
    localparam int COEF_SPAN     = 2 << FRAC_BITS;
    localparam int VTX_SPAN      = 1000 << FRAC_BITS;
    localparam int ONE_FIXED     = 1 << FRAC_BITS;

    typedef logic signed [COEF_W-1:0] t_fixed;

    typedef struct packed {
        logic                     mode;
        logic [IDX_W-1:0]         idx;
        t_fixed                   coef;
        t_fixed [VEC_N-1:0]       v;
    } t_vertex_req;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    logic                   i_s_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    t_fixed                 matrix_model [MAT_N];
    logic [HALF_W-1:0]      half_width_q;
    logic [HALF_W-1:0]      half_height_q;
    logic [OFS_W-1:0]       x_offset_q;
    logic [OFS_W-1:0]       y_offset_q;

    logic [OUT_TDATA_W-1:0] expected_screen_results [$];
    string                  field_names [OUT_FIELDS] =
        '{"out_x", "out_y", "out_z", "out_w", "screen_x", "screen_y"};

    int mismatch_count = 0;
    int vertices_checked = 0;
    int vertices_sent = 0;
    int coef_writes = 0;
    int cfg_writes = 0;
    int cycle_count = 0;
    int sender_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_request = 0;
    int rx_hold_left = 0;

    vertex_transform_screen_map #(
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_fixed dot_row(int row, t_vertex_req req);
        logic signed [67:0] acc;
        logic signed [63:0] prod;
        longint             shifted;
        acc = '0;
        for (int c = 0; c < VEC_N; c++) begin
            prod = $signed(matrix_model[row * VEC_N + c]) * $signed(req.v[c]);
            acc += prod;
        end
        // The arithmetic shift rounds toward minus infinity.
        shifted = longint'(acc >>> FRAC_BITS);
        if (shifted > 64'sh7FFF_FFFF) begin
            return 32'h7FFF_FFFF;
        end else if (shifted < -64'sh8000_0000) begin
            return 32'h8000_0000;
        end
        return t_fixed'(shifted);
    endfunction

    function automatic logic [SCR_W-1:0] to_pixel(longint coord, logic [HALF_W-1:0] half,
                                                 logic [OFS_W-1:0] ofs);
        longint t;
        // Signed division truncates toward zero.
        t = (coord + (longint'(half) << FRAC_BITS)) / (longint'(1) << FRAC_BITS)
            + longint'(ofs);
        if (t > 32767) begin
            t = 32767;
        end else if (t < -32768) begin
            t = -32768;
        end
        return SCR_W'(t);
    endfunction

    function automatic logic [OUT_TDATA_W-1:0] transform_and_map(t_vertex_req req);
        t_fixed res [VEC_N];
        for (int r = 0; r < VEC_N; r++) begin
            res[r] = dot_row(r, req);
        end
        return {to_pixel(-longint'(res[1]), half_height_q, y_offset_q),
                to_pixel(longint'(res[0]), half_width_q, x_offset_q),
                res[3], res[2], res[1], res[0]};
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_request(t_vertex_req req);
        return {{(IN_TDATA_W - IDX_W - (VEC_N + 1) * COEF_W){1'b0}}, req.v, req.coef, req.idx};
    endfunction

    function automatic t_vertex_req make_vertex(t_fixed x, t_fixed y, t_fixed z, t_fixed w);
        t_vertex_req r;
        r.mode = MODE_VERTEX;
        r.idx  = IDX_W'($urandom_range(MAT_N - 1));
        r.coef = $urandom();
        r.v    = {w, z, y, x};
        return r;
    endfunction

    function automatic t_vertex_req make_coef(int idx, t_fixed value);
        t_vertex_req r;
        r.mode = MODE_COEF;
        r.idx  = IDX_W'(idx);
        r.coef = value;
        r.v    = {$urandom(), $urandom(), $urandom(), $urandom()};
        return r;
    endfunction

    function automatic t_fixed random_fixed(int span);
        case ($urandom_range(9))
            0, 1: return $urandom();
            2: begin
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return t_fixed'(int'($urandom_range(2 * span)) - span);
        endcase
    endfunction

    function automatic t_vertex_req random_request();
        t_fixed w;
        if ($urandom_range(99) < 25) begin
            return make_coef($urandom_range(MAT_N - 1), random_fixed(COEF_SPAN));
        end
        w = $urandom_range(1) ? t_fixed'(ONE_FIXED) : random_fixed(VTX_SPAN);
        return make_vertex(random_fixed(VTX_SPAN), random_fixed(VTX_SPAN),
                           random_fixed(VTX_SPAN), w);
    endfunction

    task automatic reset_model();
        for (int i = 0; i < MAT_N; i++) begin
            matrix_model[i] = ((i % 5) == 0) ? t_fixed'(ONE_FIXED) : t_fixed'(0);
        end
        half_width_q  = HALF_WIDTH_RST;
        half_height_q = HALF_HEIGHT_RST;
        x_offset_q    = X_OFFSET_RST;
        y_offset_q    = Y_OFFSET_RST;
    endtask

    // Valid stays high after acceptance so back-to-back requests need no gap.
    task automatic send_item(input t_vertex_req req);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= pack_request(req);
        i_s_tuser  <= req.mode;
        do @(posedge i_clk); while (!o_s_tready);
        if (req.mode == MODE_COEF) begin
            matrix_model[req.idx] = req.coef;
            coef_writes++;
        end else begin
            expected_screen_results.push_back(transform_and_map(req));
            vertices_sent++;
        end
    endtask

    task automatic wait_drain();
        i_s_tvalid <= 1'b0;
        while (expected_screen_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY_PAUSE) @(posedge i_clk);
    endtask

    task automatic set_idling(int sidle, int rstall, int hold);
        @(negedge i_clk);
        sender_idle_pct = sidle;
        rx_stall_pct    = rstall;
        rx_hold_request = hold;
        @(posedge i_clk);
    endtask

    task automatic write_screen_config(input logic [CFG_DATA_W-1:0] hw, hh, xo, yo);
        logic [CFG_IDX_W-1:0]  idx  [CFG_REGS + 1];
        logic [CFG_DATA_W-1:0] data [CFG_REGS + 1];
        idx  = '{REG_HALF_WIDTH, REG_HALF_HEIGHT, REG_X_OFFSET, REG_Y_OFFSET,
                 CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, CFG_REGS))};
        data = '{hw, hh, xo, yo, CFG_DATA_W'($urandom())};
        for (int k = 0; k <= CFG_REGS; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= data[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx[k])
                REG_HALF_WIDTH:  half_width_q  = data[k][HALF_W-1:0];
                REG_HALF_HEIGHT: half_height_q = data[k][HALF_W-1:0];
                REG_X_OFFSET:    x_offset_q    = data[k][OFS_W-1:0];
                REG_Y_OFFSET:    y_offset_q    = data[k][OFS_W-1:0];
                default: ;
            endcase
            cfg_writes++;
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_identity_after_reset();
        send_item(make_vertex(0, 0, 0, 0));
        send_item(make_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        send_item(make_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        send_item(make_vertex(-98304, 163840, 1, -1));
        wait_drain();
    endtask

    task automatic test_coefficient_extremes();
        send_item(make_coef(0, 32'h7FFF_FFFF));
        send_item(make_coef(1, 32'h8000_0000));
        send_item(make_coef(5, 32'h8000_0000));
        send_item(make_coef(10, 32'h0000_8000));
        send_item(make_coef(15, 32'hFFFF_FFFF));
        send_item(make_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, -1));
        send_item(make_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_item(make_vertex(-1, -1, -1, -1));
        send_item(make_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
        // Put the identity back for the screen mapping checks.
        send_item(make_coef(0, ONE_FIXED));
        send_item(make_coef(1, 0));
        send_item(make_coef(5, ONE_FIXED));
        send_item(make_coef(10, ONE_FIXED));
        send_item(make_coef(15, ONE_FIXED));
        wait_drain();
    endtask

    task automatic test_screen_config_extremes();
        write_screen_config('0, '0, '0, '0);
        send_item(make_vertex(32'h7FFF_FFFF, 32'h8000_0000, 0, ONE_FIXED));
        send_item(make_vertex(32'h8000_0000, 32'h7FFF_FFFF, 0, ONE_FIXED));
        send_item(make_vertex(-98304, 98304, 0, ONE_FIXED));
        wait_drain();
        write_screen_config('1, '1, '1, '1);
        send_item(make_vertex(32'h7FFF_FFFF, 32'h8000_0000, 0, ONE_FIXED));
        send_item(make_vertex(32'h8000_0000, 32'h7FFF_FFFF, 0, ONE_FIXED));
        wait_drain();
    endtask

    task automatic test_random_stream(int count, int sidle, int rstall);
        write_screen_config(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                            CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()));
        set_idling(sidle, rstall, 0);
        repeat (count) send_item(random_request());
        wait_drain();
    endtask

    // The output is held off long enough for the block to fill and stall its input.
    task automatic test_output_backpressure();
        set_idling(0, 0, 300);
        repeat (40) send_item(random_request());
        wait_drain();
    endtask

    always @(posedge i_clk) begin
        if (rx_hold_request > 0) begin
            rx_hold_left    = rx_hold_request;
            rx_hold_request = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_checker
        logic [OUT_TDATA_W-1:0] want;
        logic [COEF_W-1:0]      want_f;
        logic [COEF_W-1:0]      got_f;
        int                     lsb;
        int                     w;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_screen_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with no pending vertex, expected none, actual %h",
                         $time, o_m_tdata);
            end else begin
                want = expected_screen_results.pop_front();
                vertices_checked++;
                for (int f = 0; f < OUT_FIELDS; f++) begin
                    lsb    = (f < VEC_N) ? f * COEF_W : VEC_N * COEF_W + (f - VEC_N) * SCR_W;
                    w      = (f < VEC_N) ? COEF_W : SCR_W;
                    want_f = COEF_W'((want >> lsb) & ((64'd1 << w) - 1));
                    got_f  = COEF_W'((o_m_tdata >> lsb) & ((64'd1 << w) - 1));
                    if (want_f !== got_f) begin
                        mismatch_count++;
                        $display("%0t: %s mismatch, expected %h, actual %h",
                                 $time, field_names[f], want_f, got_f);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_vertex_transform_screen_map failed");
        $finish;
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= MODE_COEF;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_HALF_WIDTH;
        i_cfg_data  <= '0;
        reset_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_identity_after_reset();
        test_coefficient_extremes();
        test_screen_config_extremes();
        test_random_stream(180, 0, 0);
        test_random_stream(150, 56, 0);
        test_random_stream(150, 0, 56);
        test_random_stream(150, 9, 9);
        test_output_backpressure();
        wait_drain();

        $display("Checked %0d transformed vertices against %0d sent, with %0d coefficient writes.",
                 vertices_checked, vertices_sent, coef_writes);
        $display("Covered %0d register writes, sender and receiver idling, and a long stall.",
                 cfg_writes);
        if (mismatch_count == 0 && expected_screen_results.size() == 0) begin
            $display("tb_vertex_transform_screen_map passed");
        end else begin
            $display("tb_vertex_transform_screen_map failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/vts_pkg.sv
hw/rtl/vts_front.sv
hw/rtl/vts_queue.sv
hw/rtl/vts_back.sv
hw/rtl/vertex_transform_screen_map.sv
test/tb_vertex_transform_screen_map.sv
